// File: rtl/gap_pkg.sv
`timescale 1ns / 1ps

package gap_pkg;

  // grid geometry: cells are addressed as {row, column}, three bits each
  localparam int CoordW    = 3;
  localparam int CellW     = 2 * CoordW;
  localparam int NCells    = 1 << CellW;
  localparam int LenW      = CellW + 1;
  localparam int CostW     = 10;
  localparam int CfgW      = 4;
  localparam int MaxColsDef = 8;
  localparam int MaxRowsDef = 8;

  // operation codes of an input beat
  localparam logic [1:0] OpWrFixed  = 2'd0;
  localparam logic [1:0] OpClrMove  = 2'd1;
  localparam logic [1:0] OpWrMove   = 2'd2;
  localparam logic [1:0] OpFindPath = 2'd3;

  // path kinds
  localparam logic [1:0] KindFull    = 2'd0;
  localparam logic [1:0] KindDetour  = 2'd1;
  localparam logic [1:0] KindFixed   = 2'd2;
  localparam logic [1:0] KindNone    = 2'd3;

  typedef logic [CellW-1:0] cell_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic              passable;
    logic [CoordW-1:0] goal_x;
    logic [CoordW-1:0] goal_y;
  } gap_cmd_t;

  typedef struct packed {
    logic [CoordW-1:0] step_x;
    logic [CoordW-1:0] step_y;
    logic [1:0]        path_kind;
    logic              last_step;
  } gap_res_t;

  // map write port
  typedef struct packed {
    logic  we_fixed;
    logic  we_moving;
    logic  clr_moving;
    cell_t addr;
    logic  data;
  } gap_map_wr_t;

  // map read data
  typedef struct packed {
    logic fixed_ok;
    logic moving_ok;
  } gap_map_bits_t;

  // search request
  typedef struct packed {
    cell_t start;
    cell_t goal;
    logic  fixed_only;
    logic  bank;
  } gap_sreq_t;

  // search response
  typedef struct packed {
    logic            done;
    logic            found;
    logic [LenW-1:0] len;
  } gap_srsp_t;

  // path buffer write port
  typedef struct packed {
    logic            we;
    logic [LenW-1:0] addr;
    cell_t           data;
  } gap_buf_wr_t;

endpackage

// File: rtl/grid_astar_path_search.sv
`timescale 1ns / 1ps

// Map writes and clears leave busy low. An in-grid path request runs a full-map search,
// then a fixed-map search if that fails, and one search per detour try after a fixed
// path; an expansion scans the open list, closes the gap left by the popped entry and
// then tries the four neighbors, and each path cell is traced back and later emitted.
// Results are strobed for one cycle each and cannot be stalled. Reset leaves both
// maps passable, no search open.

module grid_astar_path_search
  import gap_pkg::*;
#(
  parameter int MAX_COLS = MaxColsDef,
  parameter int MAX_ROWS = MaxRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  gap_cmd_t    cmd_i,
  output logic        result_valid_o,
  output gap_res_t    result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [CfgW-1:0] ColsLim = CfgW'(MAX_COLS);
  localparam logic [CfgW-1:0] RowsLim = CfgW'(MAX_ROWS);

  typedef enum logic [12:0] {
    T_IDLE   = 13'b0000000000001,
    T_S1     = 13'b0000000000010,
    T_W1     = 13'b0000000000100,
    T_S2     = 13'b0000000001000,
    T_W2     = 13'b0000000010000,
    T_SC_RD  = 13'b0000000100000,
    T_SC_MAP = 13'b0000001000000,
    T_SC_CHK = 13'b0000010000000,
    T_SC_TGT = 13'b0000100000000,
    T_W3     = 13'b0001000000000,
    T_EM_RD  = 13'b0010000000000,
    T_EM_OUT = 13'b0100000000000,
    T_NONE   = 13'b1000000000000
  } tstate_e;

  tstate_e state_q, state_d;
  logic [CfgW-1:0] width_q, height_q, w_use, h_use;
  cell_t start_q, goal_q, start_d, goal_d;
  logic [LenW-1:0] main_len_q, main_len_d;
  logic [CellW-1:0] j_q, j_d, em_idx_q, em_idx_d;
  logic em_bank_q, em_bank_d;
  logic [1:0] kind_q, kind_d;
  logic res_valid_q, res_valid_d;
  gap_res_t res_q, res_d;

  logic accept, in_grid, goal_in;
  gap_map_wr_t map_wr;
  cell_t map_raddr, eng_map_raddr, buf_rd;
  gap_map_bits_t map_rd;
  gap_buf_wr_t buf_wr;
  logic [LenW-1:0] buf_raddr;
  logic eng_req;
  gap_sreq_t eng_cmd;
  gap_srsp_t eng_rsp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(8);
      height_q <= CfgW'(8);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) height_q <= pwdata[CfgW-1:0];
      else width_q <= pwdata[CfgW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {28'd0, paddr[2] ? height_q : width_q};

  // grid size in use, saturated to the supported range
  assign w_use = (width_q == '0) ? CfgW'(1) : ((width_q > ColsLim) ? ColsLim : width_q);
  assign h_use = (height_q == '0) ? CfgW'(1) : ((height_q > RowsLim) ? RowsLim : height_q);

  assign busy    = state_q != T_IDLE;
  assign accept  = start && !busy;
  assign in_grid = ({1'b0, cmd_i.pos_x} < w_use) && ({1'b0, cmd_i.pos_y} < h_use);
  assign goal_in = ({1'b0, cmd_i.goal_x} < w_use) && ({1'b0, cmd_i.goal_y} < h_use);

  always_comb begin
    map_wr = '0;
    map_wr.addr = {cmd_i.pos_y, cmd_i.pos_x};
    map_wr.data = cmd_i.passable;
    if (accept) begin
      unique case (cmd_i.op)
        OpWrFixed:  map_wr.we_fixed = in_grid;
        OpClrMove:  map_wr.clr_moving = 1'b1;
        OpWrMove:   map_wr.we_moving = in_grid;
        OpFindPath: ;
        default: ;
      endcase
    end
  end

  gap_maps u_maps (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (map_wr),
    .raddr_i (map_raddr),
    .rdata_o (map_rd)
  );

  gap_path_buf u_buf (
    .clk_i   (clk_i),
    .wr_i    (buf_wr),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rd)
  );

  gap_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (eng_req),
    .cmd_i       (eng_cmd),
    .w_lim_i     (w_use),
    .h_lim_i     (h_use),
    .map_raddr_o (eng_map_raddr),
    .map_rdata_i (map_rd),
    .buf_wr_o    (buf_wr),
    .rsp_o       (eng_rsp)
  );

  assign map_raddr = (state_q == T_SC_MAP) ? buf_rd : eng_map_raddr;

  // request sequencing: full map, fixed map, then detours to blocked cells
  always_comb begin
    state_d = state_q;
    start_d = start_q; goal_d = goal_q;
    main_len_d = main_len_q; j_d = j_q;
    em_idx_d = em_idx_q; em_bank_d = em_bank_q; kind_d = kind_q;
    res_valid_d = 1'b0;
    res_d = res_q;
    buf_raddr = {em_bank_q, em_idx_q};
    eng_req = 1'b0;
    eng_cmd.start = start_q;
    eng_cmd.goal = goal_q;
    eng_cmd.fixed_only = 1'b0;
    eng_cmd.bank = 1'b0;

    unique case (state_q)
      T_IDLE: begin
        if (accept && cmd_i.op == OpFindPath) begin
          start_d = {cmd_i.pos_y, cmd_i.pos_x};
          goal_d = {cmd_i.goal_y, cmd_i.goal_x};
          state_d = (in_grid && goal_in) ? T_S1 : T_NONE;
        end
      end
      T_S1: begin
        eng_req = 1'b1;
        state_d = T_W1;
      end
      T_W1: begin
        if (eng_rsp.done) begin
          if (eng_rsp.found) begin
            kind_d = KindFull;
            em_bank_d = 1'b0;
            em_idx_d = CellW'(eng_rsp.len - LenW'(1));
            state_d = T_EM_RD;
          end else begin
            state_d = T_S2;
          end
        end
      end
      T_S2: begin
        eng_req = 1'b1;
        eng_cmd.fixed_only = 1'b1;
        state_d = T_W2;
      end
      T_W2: begin
        if (eng_rsp.done) begin
          if (eng_rsp.found) begin
            main_len_d = eng_rsp.len;
            kind_d = KindFixed;
            j_d = '0;
            state_d = T_SC_RD;
          end else begin
            state_d = T_NONE;
          end
        end
      end
      // walk the fixed path from its end toward the second cell
      T_SC_RD: begin
        if (({1'b0, j_q} + LenW'(1)) < main_len_q) begin
          buf_raddr = {1'b0, j_q};
          state_d = T_SC_MAP;
        end else begin
          kind_d = KindFixed;
          em_bank_d = 1'b0;
          em_idx_d = CellW'(main_len_q - LenW'(1));
          state_d = T_EM_RD;
        end
      end
      T_SC_MAP: begin
        state_d = T_SC_CHK;
      end
      T_SC_CHK: begin
        if (map_rd.fixed_ok && map_rd.moving_ok) begin
          j_d = j_q + CellW'(1);
          state_d = T_SC_RD;
        end else begin
          buf_raddr = {1'b0, j_q + CellW'(1)};
          state_d = T_SC_TGT;
        end
      end
      T_SC_TGT: begin
        eng_req = 1'b1;
        eng_cmd.goal = buf_rd;
        eng_cmd.bank = 1'b1;
        state_d = T_W3;
      end
      T_W3: begin
        if (eng_rsp.done) begin
          if (eng_rsp.found) begin
            kind_d = KindDetour;
            em_bank_d = 1'b1;
            em_idx_d = CellW'(eng_rsp.len - LenW'(1));
            state_d = T_EM_RD;
          end else begin
            j_d = j_q + CellW'(1);
            state_d = T_SC_RD;
          end
        end
      end
      // emit stored cells from start to end
      T_EM_RD: begin
        state_d = T_EM_OUT;
      end
      T_EM_OUT: begin
        res_valid_d = 1'b1;
        res_d.step_x = buf_rd[CoordW-1:0];
        res_d.step_y = buf_rd[CellW-1:CoordW];
        res_d.path_kind = kind_q;
        res_d.last_step = em_idx_q == '0;
        if (em_idx_q == '0) begin
          state_d = T_IDLE;
        end else begin
          em_idx_d = em_idx_q - CellW'(1);
          state_d = T_EM_RD;
        end
      end
      T_NONE: begin
        res_valid_d = 1'b1;
        res_d = gap_res_t'{step_x: '0, step_y: '0, path_kind: KindNone, last_step: 1'b1};
        state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d; goal_q <= goal_d;
    main_len_q <= main_len_d; j_q <= j_d;
    em_idx_q <= em_idx_d; em_bank_q <= em_bank_d; kind_q <= kind_d;
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o = res_q;

endmodule

// File: rtl/gap_maps.sv
`timescale 1ns / 1ps

module gap_maps
  import gap_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gap_map_wr_t   wr_i,
  input  cell_t         raddr_i,
  output gap_map_bits_t rdata_o
);

  logic fixed_mem  [NCells];
  logic moving_mem [NCells];
  logic [NCells-1:0] fixed_vld_q;
  logic [NCells-1:0] moving_vld_q;
  logic fixed_rd_q, moving_rd_q, fixed_rv_q, moving_rv_q;

  // written flags: an unwritten cell reads as passable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_vld_q  <= '0;
      moving_vld_q <= '0;
    end else begin
      if (wr_i.we_fixed) fixed_vld_q[wr_i.addr] <= 1'b1;
      if (wr_i.clr_moving) begin
        moving_vld_q <= '0;
      end else if (wr_i.we_moving) begin
        moving_vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  // cell storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.we_fixed) fixed_mem[wr_i.addr] <= wr_i.data;
    if (wr_i.we_moving) moving_mem[wr_i.addr] <= wr_i.data;
    fixed_rd_q  <= fixed_mem[raddr_i];
    moving_rd_q <= moving_mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_rv_q  <= 1'b0;
      moving_rv_q <= 1'b0;
    end else begin
      fixed_rv_q  <= fixed_vld_q[raddr_i];
      moving_rv_q <= moving_vld_q[raddr_i];
    end
  end

  assign rdata_o.fixed_ok  = fixed_rv_q ? fixed_rd_q : 1'b1;
  assign rdata_o.moving_ok = moving_rv_q ? moving_rd_q : 1'b1;

endmodule

// File: rtl/gap_path_buf.sv
`timescale 1ns / 1ps

module gap_path_buf
  import gap_pkg::*;
(
  input  logic            clk_i,
  input  gap_buf_wr_t     wr_i,
  input  logic [LenW-1:0] raddr_i,
  output cell_t           rdata_o
);

  // two banks of path cells, goal first
  cell_t mem [2*NCells];
  cell_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) mem[wr_i.addr] <= wr_i.data;
    rd_q <= mem[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

// File: rtl/gap_search.sv
`timescale 1ns / 1ps

module gap_search
  import gap_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_i,
  input  gap_sreq_t       cmd_i,
  input  logic [CfgW-1:0] w_lim_i,
  input  logic [CfgW-1:0] h_lim_i,
  output cell_t           map_raddr_o,
  input  gap_map_bits_t   map_rdata_i,
  output gap_buf_wr_t     buf_wr_o,
  output gap_srsp_t       rsp_o
);

  localparam logic [1:0] StFree = 2'd0;
  localparam logic [1:0] StOpen = 2'd1;
  localparam logic [1:0] StDone = 2'd2;
  localparam logic [LenW-1:0] LinkNone = LenW'(NCells);
  localparam logic [CostW:0]  StepCost = (CostW+1)'(10);
  localparam logic [LenW-1:0] CellCnt  = LenW'(NCells);
  localparam logic [1:0] DirUp = 2'd0, DirLeft = 2'd1, DirRight = 2'd2, DirDown = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [LenW-1:0]  parent;
    logic [CostW-1:0] cost;
  } node_t;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_INIT     = 14'b00000000000010,
    S_SEL_ORD  = 14'b00000000000100,
    S_SEL_NODE = 14'b00000000001000,
    S_SEL_CMP  = 14'b00000000010000,
    S_POP_RD   = 14'b00000000100000,
    S_POP_WR   = 14'b00000001000000,
    S_POP_DONE = 14'b00000010000000,
    S_EXP_CHK  = 14'b00000100000000,
    S_EXP_EVAL = 14'b00001000000000,
    S_NEXT     = 14'b00010000000000,
    S_RC_RD    = 14'b00100000000000,
    S_RC_NX    = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } sstate_e;

  function automatic logic [7:0] heur(cell_t c, cell_t g);
    logic [CoordW-1:0] dx, dy;
    logic [CoordW:0]   s;
    dx = (c[CoordW-1:0] > g[CoordW-1:0]) ? c[CoordW-1:0] - g[CoordW-1:0]
                                         : g[CoordW-1:0] - c[CoordW-1:0];
    dy = (c[CellW-1:CoordW] > g[CellW-1:CoordW]) ? c[CellW-1:CoordW] - g[CellW-1:CoordW]
                                                 : g[CellW-1:CoordW] - c[CellW-1:CoordW];
    s = {1'b0, dx} + {1'b0, dy};
    return (8'(s) << 3) + (8'(s) << 1);
  endfunction

  sstate_e state_q, state_d;
  cell_t start_q, goal_q, cur_q, sel_q, nb_q, rc_q;
  cell_t start_d, goal_d, cur_d, sel_d, nb_d, rc_d;
  logic  fixed_only_q, bank_q, found_q, fixed_only_d, bank_d, found_d;
  logic [LenW-1:0] cnt_q, cnt_d, idx_q, idx_d, len_q, len_d;
  logic [CellW-1:0] bi_q, bi_d;
  logic [CostW:0] bf_q, bf_d;
  logic [CostW-1:0] bcost_q, bcost_d;
  logic [LenW-1:0] bpar_q, bpar_d;
  logic [1:0] dir_q, dir_d;

  // node store: status, parent and cost per cell, cleared per search by flags
  node_t node_mem [NCells];
  logic [NCells-1:0] node_vld_q;
  node_t node_rd_q, node_eff, node_wdata;
  logic  node_rv_q, node_we, node_clr;
  cell_t node_waddr, node_raddr;

  // open list in insertion order
  cell_t order_mem [NCells];
  cell_t ord_rd_q, ord_wdata;
  logic  ord_we;
  logic [CellW-1:0] ord_waddr, ord_raddr;

  logic [CostW:0] f_val, ng;
  logic take, nb_ok, cell_ok;
  cell_t nb_cell;
  logic [1:0] st_new;

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rd_q <= node_mem[node_raddr];
    if (ord_we) order_mem[ord_waddr] <= ord_wdata;
    ord_rd_q <= order_mem[ord_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_vld_q <= '0;
      node_rv_q  <= 1'b0;
    end else begin
      if (node_clr) begin
        node_vld_q <= '0;
      end else if (node_we) begin
        node_vld_q[node_waddr] <= 1'b1;
      end
      node_rv_q <= node_vld_q[node_raddr];
    end
  end

  assign node_eff = node_rv_q ? node_rd_q : node_t'{status: StFree, parent: LinkNone, cost: '0};

  always_comb begin
    state_d = state_q;
    start_d = start_q; goal_d = goal_q; cur_d = cur_q; sel_d = sel_q;
    nb_d = nb_q; rc_d = rc_q;
    fixed_only_d = fixed_only_q; bank_d = bank_q; found_d = found_q;
    cnt_d = cnt_q; idx_d = idx_q; len_d = len_q; bi_d = bi_q; bf_d = bf_q;
    bcost_d = bcost_q; bpar_d = bpar_q; dir_d = dir_q;
    node_we = 1'b0; node_clr = 1'b0; node_waddr = cur_q; node_raddr = nb_q;
    node_wdata = node_t'{status: StDone, parent: bpar_q, cost: bcost_q};
    ord_we = 1'b0; ord_waddr = idx_q[CellW-1:0]; ord_raddr = idx_q[CellW-1:0];
    ord_wdata = ord_rd_q;
    buf_wr_o = '0;
    f_val = {1'b0, node_eff.cost} + (CostW+1)'(heur(sel_q, goal_q));
    take = (idx_q == '0) || (f_val < bf_q);
    ng = {1'b0, bcost_q} + StepCost;
    nb_ok = 1'b0;
    nb_cell = cur_q;
    cell_ok = map_rdata_i.fixed_ok && (fixed_only_q || map_rdata_i.moving_ok);
    st_new = StOpen;

    // neighbor of the current cell in direction dir
    unique case (dir_q)
      DirUp: begin
        nb_ok = cur_q[CellW-1:CoordW] != '0;
        nb_cell = {cur_q[CellW-1:CoordW] - CoordW'(1), cur_q[CoordW-1:0]};
      end
      DirLeft: begin
        nb_ok = cur_q[CoordW-1:0] != '0;
        nb_cell = {cur_q[CellW-1:CoordW], cur_q[CoordW-1:0] - CoordW'(1)};
      end
      DirRight: begin
        nb_ok = ({1'b0, cur_q[CoordW-1:0]} + CfgW'(1)) < w_lim_i;
        nb_cell = {cur_q[CellW-1:CoordW], cur_q[CoordW-1:0] + CoordW'(1)};
      end
      DirDown: begin
        nb_ok = ({1'b0, cur_q[CellW-1:CoordW]} + CfgW'(1)) < h_lim_i;
        nb_cell = {cur_q[CellW-1:CoordW] + CoordW'(1), cur_q[CoordW-1:0]};
      end
      default: ;
    endcase

    unique case (state_q)
      S_IDLE: begin
        if (req_i) begin
          start_d = cmd_i.start;
          goal_d = cmd_i.goal;
          fixed_only_d = cmd_i.fixed_only;
          bank_d = cmd_i.bank;
          node_clr = 1'b1;
          state_d = S_INIT;
        end
      end
      // seed the open list with the start cell
      S_INIT: begin
        node_we = 1'b1;
        node_waddr = start_q;
        node_wdata = node_t'{status: StOpen, parent: LinkNone, cost: '0};
        ord_we = 1'b1;
        ord_waddr = '0;
        ord_wdata = start_q;
        cnt_d = LenW'(1);
        idx_d = '0;
        state_d = S_SEL_ORD;
      end
      // scan the open list for the first lowest f
      S_SEL_ORD: begin
        state_d = S_SEL_NODE;
      end
      S_SEL_NODE: begin
        node_raddr = ord_rd_q;
        sel_d = ord_rd_q;
        state_d = S_SEL_CMP;
      end
      S_SEL_CMP: begin
        if (take) begin
          bf_d = f_val;
          bi_d = idx_q[CellW-1:0];
          cur_d = sel_q;
          bcost_d = node_eff.cost;
          bpar_d = node_eff.parent;
        end
        if ((idx_q + LenW'(1)) < cnt_q) begin
          idx_d = idx_q + LenW'(1);
          state_d = S_SEL_ORD;
        end else begin
          idx_d = {1'b0, take ? idx_q[CellW-1:0] : bi_q};
          state_d = S_POP_RD;
        end
      end
      // close the gap left by the removed entry
      S_POP_RD: begin
        ord_raddr = CellW'(idx_q + LenW'(1));
        state_d = ((idx_q + LenW'(1)) < cnt_q) ? S_POP_WR : S_POP_DONE;
      end
      S_POP_WR: begin
        ord_we = 1'b1;
        idx_d = idx_q + LenW'(1);
        state_d = S_POP_RD;
      end
      S_POP_DONE: begin
        cnt_d = cnt_q - LenW'(1);
        node_we = 1'b1;
        if (cur_q == goal_q) begin
          rc_d = goal_q;
          len_d = '0;
          state_d = S_RC_RD;
        end else begin
          dir_d = DirUp;
          state_d = S_EXP_CHK;
        end
      end
      // expand the four neighbors in order
      S_EXP_CHK: begin
        if (nb_ok) begin
          nb_d = nb_cell;
          node_raddr = nb_cell;
          state_d = S_EXP_EVAL;
        end else if (dir_q == DirDown) begin
          state_d = S_NEXT;
        end else begin
          dir_d = dir_q + 2'd1;
        end
      end
      S_EXP_EVAL: begin
        if (cell_ok && node_eff.status != StDone &&
            (node_eff.status != StOpen || ng < {1'b0, node_eff.cost})) begin
          if (node_eff.status != StOpen) begin
            st_new = (cnt_q < CellCnt) ? StOpen : node_eff.status;
          end
          node_we = 1'b1;
          node_waddr = nb_q;
          node_wdata = node_t'{status: st_new, parent: {1'b0, cur_q}, cost: ng[CostW-1:0]};
          if (node_eff.status != StOpen && cnt_q < CellCnt) begin
            ord_we = 1'b1;
            ord_waddr = cnt_q[CellW-1:0];
            ord_wdata = nb_q;
            cnt_d = cnt_q + LenW'(1);
          end
        end
        if (dir_q == DirDown) begin
          state_d = S_NEXT;
        end else begin
          dir_d = dir_q + 2'd1;
          state_d = S_EXP_CHK;
        end
      end
      S_NEXT: begin
        if (cnt_q != '0) begin
          idx_d = '0;
          state_d = S_SEL_ORD;
        end else begin
          found_d = 1'b0;
          len_d = '0;
          state_d = S_FIN;
        end
      end
      // follow parent links from the goal into the path buffer
      S_RC_RD: begin
        buf_wr_o.we = 1'b1;
        buf_wr_o.addr = {bank_q, len_q[CellW-1:0]};
        buf_wr_o.data = rc_q;
        len_d = len_q + LenW'(1);
        node_raddr = rc_q;
        state_d = S_RC_NX;
      end
      S_RC_NX: begin
        if (node_eff.parent != LinkNone && len_q < CellCnt) begin
          rc_d = node_eff.parent[CellW-1:0];
          state_d = S_RC_RD;
        end else begin
          found_d = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      found_q <= 1'b0;
      len_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      found_q <= found_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d; goal_q <= goal_d; cur_q <= cur_d; sel_q <= sel_d;
    nb_q <= nb_d; rc_q <= rc_d;
    fixed_only_q <= fixed_only_d; bank_q <= bank_d;
    idx_q <= idx_d; bi_q <= bi_d; bf_q <= bf_d;
    bcost_q <= bcost_d; bpar_q <= bpar_d; dir_q <= dir_d;
  end

  assign map_raddr_o = nb_d;
  assign rsp_o.done  = state_q == S_FIN;
  assign rsp_o.found = found_q;
  assign rsp_o.len   = len_q;

endmodule
